@@ rtl/vmc_pkg.sv @@
package vmc_pkg;

    localparam int unsigned W = 32;

    typedef struct packed {
        logic signed [W-1:0] vec_x;
        logic signed [W-1:0] vec_y;
        logic signed [W-1:0] target_len;
        logic                mode;
    } t_in_word;

    typedef struct packed {
        logic signed [W-1:0] out_x;
        logic signed [W-1:0] out_y;
        logic                was_rescaled;
    } t_out_word;

endpackage

@@ rtl/vmc_sqrt_step.sv @@
// One restoring square-root step: decides one root bit per stage.
module vmc_sqrt_step #(
    parameter int unsigned RW = 32
) (
    input  logic [2*RW-1:0] i_rad,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    output logic [2*RW-1:0] o_rad,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root
);
    logic [RW+1:0] w_trial;
    logic [RW+1:0] w_sub;

    assign w_trial = {i_rem[RW-1:0], i_rad[2*RW-1 -: 2]};
    assign w_sub   = {i_root, 2'b01};
    assign o_rad   = {i_rad[2*RW-3:0], 2'b00};
    always_comb begin
        if (w_trial >= w_sub) begin
            o_rem  = w_trial - w_sub;
            o_root = {i_root[RW-2:0], 1'b1};
        end else begin
            o_rem  = w_trial;
            o_root = {i_root[RW-2:0], 1'b0};
        end
    end
endmodule

@@ rtl/vmc_div_step.sv @@
// One restoring divide step: one quotient bit per stage.
module vmc_div_step #(
    parameter int unsigned NW = 64,
    parameter int unsigned DW = 32
) (
    input  logic [NW-1:0] i_num,
    input  logic [DW:0]   i_rem,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_num,
    output logic [DW:0]   o_rem,
    output logic          o_bit
);
    logic [DW+1:0] w_trial;

    assign w_trial = {i_rem, i_num[NW-1]};
    assign o_num   = {i_num[NW-2:0], 1'b0};
    always_comb begin
        if (w_trial >= {2'b00, i_den}) begin
            o_rem = (DW+1)'(w_trial - {2'b00, i_den});
            o_bit = 1'b1;
        end else begin
            o_rem = (DW+1)'(w_trial);
            o_bit = 1'b0;
        end
    end
endmodule

@@ rtl/vector_magnitude_clamp_top.sv @@
// Throughput: one word per cycle while the output is not stalled; the root and divide stages each decide one bit.
// The pipeline advances as a whole when the output register is free or taken.
// Reset (synchronous, active low) clears all valid bits; data needs no reset.
module vector_magnitude_clamp_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vmc_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output vmc_pkg::t_out_word o_data
);
    import vmc_pkg::*;

    localparam int unsigned NS = W;      // root stages are NS + 1
    localparam int unsigned ND = 2 * W;  // divide stages

    typedef struct packed {
        logic [W-1:0] ax, ay, at;
        logic         nx, ny;
        logic [W-1:0] rx, ry;
        logic         apply, zero;
    } t_side;

    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // stage 0: magnitudes
    t_side r_s0;
    logic  r_v0;
    logic  r_mode0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (w_adv) r_v0 <= i_valid;
        if (w_adv) begin
            r_s0.nx   <= i_data.vec_x[W-1];
            r_s0.ny   <= i_data.vec_y[W-1];
            r_s0.ax   <= i_data.vec_x[W-1] ? W'(-i_data.vec_x) : i_data.vec_x;
            r_s0.ay   <= i_data.vec_y[W-1] ? W'(-i_data.vec_y) : i_data.vec_y;
            r_s0.at   <= i_data.target_len[W-1] ? W'(-i_data.target_len)
                                                : i_data.target_len;
            r_s0.zero <= i_data.target_len[W-1] || (i_data.target_len == '0);
            r_s0.rx   <= i_data.vec_x;
            r_s0.ry   <= i_data.vec_y;
            r_s0.apply <= 1'b0;
            r_mode0   <= i_data.mode;
        end
    end

    // stage 1: squares
    t_side r_s1;
    logic  r_v1, r_mode1;
    logic [2*W-1:0] r_xx, r_yy, r_tt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= r_v0;
        if (w_adv) begin
            r_s1    <= r_s0;
            r_mode1 <= r_mode0;
            r_xx    <= r_s0.ax * r_s0.ax;
            r_yy    <= r_s0.ay * r_s0.ay;
            r_tt    <= r_s0.at * r_s0.at;
        end
    end

    // stage 2: sum and decision
    logic [2*W:0] w_sq;
    assign w_sq = {1'b0, r_xx} + {1'b0, r_yy};
    t_side w_s2;
    always_comb begin
        w_s2       = r_s1;
        w_s2.apply = r_mode1 || (w_sq > {1'b0, r_tt});
        w_s2.zero  = r_s1.zero || (w_sq == '0);
    end
    t_side r_s2;
    logic  r_v2;
    logic [2*W:0] r_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
        if (w_adv) begin
            r_s2 <= w_s2;
            r_sq <= w_sq;
        end
    end

    // root pipeline over the 2W+2 bit radicand (root fits in W+1 bits)
    localparam int unsigned RW = W + 1;
    logic [2*RW-1:0] r_rad  [NS+2];
    logic [RW+1:0]   r_rem  [NS+2];
    logic [RW-1:0]   r_root [NS+2];
    t_side           r_sr   [NS+2];
    logic            r_vr   [NS+2];
    always_comb begin
        r_rad[0]  = {1'b0, r_sq};
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_sr[0]   = r_s2;
        r_vr[0]   = r_v2;
    end
    for (genvar g = 0; g < NS + 1; g++) begin : g_sqrt
        logic [2*RW-1:0] w_rad;
        logic [RW+1:0]   w_rem;
        logic [RW-1:0]   w_root;
        vmc_sqrt_step #(.RW(RW)) u_step (
            .i_rad(r_rad[g]), .i_rem(r_rem[g]), .i_root(r_root[g]),
            .o_rad(w_rad), .o_rem(w_rem), .o_root(w_root)
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vr[g+1] <= 1'b0;
            else if (w_adv) r_vr[g+1] <= r_vr[g];
            if (w_adv) begin
                r_rad[g+1]  <= w_rad;
                r_rem[g+1]  <= w_rem;
                r_root[g+1] <= w_root;
                r_sr[g+1]   <= r_sr[g];
            end
        end
    end

    // products |c|*T, then both divides by the root in lockstep
    t_side          r_sp;
    logic           r_vp;
    logic [W-1:0]   r_den;
    logic [2*W-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= 1'b0;
        else if (w_adv) r_vp <= r_vr[NS+1];
        if (w_adv) begin
            r_sp  <= r_sr[NS+1];
            // root is below 2^W since sum of squares is at most 2^(2W-1)
            r_den <= r_root[NS+1][W-1:0] | W'(r_root[NS+1] == '0);
            r_px  <= r_sr[NS+1].ax * r_sr[NS+1].at;
            r_py  <= r_sr[NS+1].ay * r_sr[NS+1].at;
        end
    end

    logic [2*W-1:0] r_nx [ND+1];
    logic [2*W-1:0] r_ny [ND+1];
    logic [W:0]     r_mx [ND+1];
    logic [W:0]     r_my [ND+1];
    logic [2*W-1:0] r_qx [ND+1];
    logic [2*W-1:0] r_qy [ND+1];
    logic [W-1:0]   r_dd [ND+1];
    t_side          r_sd [ND+1];
    logic           r_vd [ND+1];
    always_comb begin
        r_nx[0] = r_px; r_ny[0] = r_py;
        r_mx[0] = '0;   r_my[0] = '0;
        r_qx[0] = '0;   r_qy[0] = '0;
        r_dd[0] = r_den; r_sd[0] = r_sp; r_vd[0] = r_vp;
    end
    for (genvar g = 0; g < ND; g++) begin : g_div
        logic [2*W-1:0] w_nx, w_ny;
        logic [W:0]     w_mx, w_my;
        logic           w_bx, w_by;
        vmc_div_step #(.NW(2*W), .DW(W)) u_dx (
            .i_num(r_nx[g]), .i_rem(r_mx[g]), .i_den(r_dd[g]),
            .o_num(w_nx), .o_rem(w_mx), .o_bit(w_bx)
        );
        vmc_div_step #(.NW(2*W), .DW(W)) u_dy (
            .i_num(r_ny[g]), .i_rem(r_my[g]), .i_den(r_dd[g]),
            .o_num(w_ny), .o_rem(w_my), .o_bit(w_by)
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vd[g+1] <= 1'b0;
            else if (w_adv) r_vd[g+1] <= r_vd[g];
            if (w_adv) begin
                r_nx[g+1] <= w_nx; r_ny[g+1] <= w_ny;
                r_mx[g+1] <= w_mx; r_my[g+1] <= w_my;
                r_qx[g+1] <= {r_qx[g][2*W-2:0], w_bx};
                r_qy[g+1] <= {r_qy[g][2*W-2:0], w_by};
                r_dd[g+1] <= r_dd[g];
                r_sd[g+1] <= r_sd[g];
            end
        end
    end

    // output register
    t_side        w_f;
    logic [W-1:0] w_qx, w_qy;
    assign w_f  = r_sd[ND];
    assign w_qx = r_qx[ND][W-1:0];
    assign w_qy = r_qy[ND][W-1:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_adv) o_valid <= r_vd[ND];
        if (w_adv) begin
            if (!w_f.apply) begin
                o_data.out_x        <= w_f.rx;
                o_data.out_y        <= w_f.ry;
                o_data.was_rescaled <= 1'b0;
            end else if (w_f.zero) begin
                o_data.out_x        <= '0;
                o_data.out_y        <= '0;
                o_data.was_rescaled <= 1'b1;
            end else begin
                o_data.out_x        <= w_f.nx ? W'(-w_qx) : w_qx;
                o_data.out_y        <= w_f.ny ? W'(-w_qy) : w_qy;
                o_data.was_rescaled <= 1'b1;
            end
        end
    end
endmodule

@@ rtl/vmc_checker.sv @@
module vmc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input vmc_pkg::t_out_word o_data
);
    import vmc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word dropped or changed under stall");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output register");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input word withdrawn before it was taken");
endmodule

bind vector_magnitude_clamp_top vmc_checker u_vmc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
